FILE: design/tccs_pkg.sv
`default_nettype none

package tccs_pkg;

    localparam int IDX_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int OUT_ADDR_W = 14;

    localparam logic [1:0] MODE_PUT         = 2'd0;
    localparam logic [1:0] MODE_SCROLL_UP   = 2'd1;
    localparam logic [1:0] MODE_SCROLL_DOWN = 2'd2;
    localparam logic [1:0] MODE_SELECT      = 2'd3;

    localparam logic [CHAR_W-1:0] NL_CODE    = 8'h0A;
    localparam logic [CHAR_W-1:0] BS_CODE    = 8'h08;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CHAR,
        OP_SCROLL_UP,
        OP_SCROLL_DOWN,
        OP_SELECT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  console;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

endpackage

`default_nettype wire

FILE: design/tccs_front.sv
`default_nettype none

module tccs_front
    import tccs_pkg::*;
#(
    parameter int NUM_CONSOLES = 4
) (
    input  wire logic              i_valid,
    input  wire logic [1:0]        i_mode,
    input  wire logic [IDX_W-1:0]  i_console_index,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_q_full,
    output logic                   o_ready,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic idx_ok;

    assign idx_ok  = {1'b0, i_console_index} < (IDX_W+1)'(NUM_CONSOLES);
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd.console = i_console_index;
        o_cmd.ch      = i_char_code;
        o_cmd.op      = OP_NOP;
        if (idx_ok) begin
            unique case (i_mode)
                MODE_PUT: begin
                    if (i_char_code == NL_CODE) begin
                        o_cmd.op = OP_NEWLINE;
                    end else if (i_char_code == BS_CODE) begin
                        o_cmd.op = OP_BACKSPACE;
                    end else begin
                        o_cmd.op = OP_CHAR;
                    end
                end
                MODE_SCROLL_UP:   o_cmd.op = OP_SCROLL_UP;
                MODE_SCROLL_DOWN: o_cmd.op = OP_SCROLL_DOWN;
                MODE_SELECT:      o_cmd.op = OP_SELECT;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/tccs_queue.sv
`default_nettype none

module tccs_queue
    import tccs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_nonempty,
    output t_cmd      o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_cmd      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/tccs_back.sv
`default_nettype none

module tccs_back
    import tccs_pkg::*;
#(
    parameter int NUM_CONSOLES = 4,
    parameter int SCREEN_COLS  = 80,
    parameter int SCREEN_CELLS = 2000,
    parameter int VIDEO_WORDS  = 16384
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_nonempty,
    input  wire t_cmd                  i_cmd,
    input  wire logic [ATTR_W-1:0]     i_attr,
    input  wire logic                  i_ready,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic                       o_write_valid,
    output logic [OUT_ADDR_W-1:0]      o_write_addr,
    output logic [CHAR_W-1:0]          o_write_char,
    output logic [ATTR_W-1:0]          o_write_attr,
    output logic                       o_display_update,
    output logic [OUT_ADDR_W-1:0]      o_cursor_out,
    output logic [OUT_ADDR_W-1:0]      o_start_out
);

    localparam int REGION = VIDEO_WORDS / NUM_CONSOLES;
    localparam int AW     = $clog2(VIDEO_WORDS);
    localparam int EW     = $clog2(VIDEO_WORDS + SCREEN_CELLS + SCREEN_COLS + 1);
    localparam int CIW    = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;
    localparam int COL_W  = $clog2(SCREEN_COLS);

    // per-console state; r_col tracks (cursor - origin) mod SCREEN_COLS
    logic [AW-1:0]    r_cursor [NUM_CONSOLES];
    logic [AW-1:0]    r_view   [NUM_CONSOLES];
    logic [COL_W-1:0] r_col    [NUM_CONSOLES];
    logic [CIW-1:0]   r_active;

    logic                  r_out_valid;
    logic                  r_write_valid;
    logic [OUT_ADDR_W-1:0] r_write_addr;
    logic [CHAR_W-1:0]     r_write_char;
    logic [ATTR_W-1:0]     r_write_attr;
    logic                  r_display_update;
    logic [OUT_ADDR_W-1:0] r_cursor_out;
    logic [OUT_ADDR_W-1:0] r_start_out;

    logic [CIW-1:0]    cmd_c;
    logic [EW-1:0]     origin;
    logic [EW-1:0]     region_end;
    logic [EW-1:0]     cur;
    logic [EW-1:0]     vs;
    logic [COL_W-1:0]  col;
    logic              down_ok;
    logic              is_put;

    logic [EW-1:0]     n_cur;
    logic [EW-1:0]     n_vs;
    logic [COL_W-1:0]  n_col;
    logic [CIW-1:0]    n_active;
    logic              n_wv;
    logic [EW-1:0]     n_wa;
    logic [CHAR_W-1:0] n_wch;
    logic              n_du;

    logic [EW-1:0]     act_origin;

    assign o_pop = i_q_nonempty && (!r_out_valid || i_ready);

    assign cmd_c      = i_cmd.console[CIW-1:0];
    assign origin     = EW'(EW'(cmd_c) * EW'(REGION));
    assign region_end = origin + EW'(REGION);
    assign cur        = EW'(r_cursor[cmd_c]);
    assign vs         = EW'(r_view[cmd_c]);
    assign col        = r_col[cmd_c];
    assign down_ok    = (vs + EW'(SCREEN_CELLS)) < region_end;
    assign is_put     = (i_cmd.op == OP_NEWLINE) || (i_cmd.op == OP_BACKSPACE)
                     || (i_cmd.op == OP_CHAR);

    always_comb begin
        n_cur    = cur;
        n_vs     = vs;
        n_col    = col;
        n_active = r_active;
        n_wv     = 1'b0;
        n_wa     = '0;
        n_wch    = '0;
        unique case (i_cmd.op)
            OP_NEWLINE: begin
                if ((cur + EW'(SCREEN_COLS)) < region_end) begin
                    n_cur = cur - EW'(col) + EW'(SCREEN_COLS);
                    n_col = '0;
                end
            end
            OP_BACKSPACE: begin
                if (cur > origin) begin
                    n_cur = cur - EW'(1);
                    n_col = (col == '0) ? COL_W'(SCREEN_COLS - 1) : col - COL_W'(1);
                    n_wv  = 1'b1;
                    n_wa  = cur - EW'(1);
                    n_wch = SPACE_CODE;
                end
            end
            OP_CHAR: begin
                if ((cur + EW'(1)) < region_end) begin
                    n_cur = cur + EW'(1);
                    n_col = (col == COL_W'(SCREEN_COLS - 1)) ? '0 : col + COL_W'(1);
                    n_wv  = 1'b1;
                    n_wa  = cur;
                    n_wch = i_cmd.ch;
                end
            end
            OP_SCROLL_UP: begin
                if (vs > origin) begin
                    n_vs = vs - EW'(SCREEN_COLS);
                end
            end
            OP_SCROLL_DOWN: begin
                if (down_ok) begin
                    n_vs = vs + EW'(SCREEN_COLS);
                end
            end
            OP_SELECT: begin
                n_active = cmd_c;
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
        // cursor ran off the bottom of the view: one line down is enough
        if (is_put && (n_cur >= (vs + EW'(SCREEN_CELLS))) && down_ok) begin
            n_vs = vs + EW'(SCREEN_COLS);
        end
        n_du = (i_cmd.op != OP_NOP) && (n_active == cmd_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CONSOLES; k++) begin
                r_cursor[k] <= AW'(k * REGION);
                r_view[k]   <= AW'(k * REGION);
                r_col[k]    <= '0;
            end
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cursor[cmd_c] <= AW'(n_cur);
                r_view[cmd_c]   <= AW'(n_vs);
                r_col[cmd_c]    <= n_col;
                r_active        <= n_active;
                r_out_valid     <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_write_valid    <= n_wv;
            r_write_addr     <= n_wv ? OUT_ADDR_W'(n_wa) : '0;
            r_write_char     <= n_wv ? n_wch : '0;
            r_write_attr     <= n_wv ? i_attr : '0;
            r_display_update <= n_du;
            r_cursor_out     <= n_du ? OUT_ADDR_W'(n_cur) : '0;
            r_start_out      <= n_du ? OUT_ADDR_W'(n_vs) : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_write_valid    = r_write_valid;
    assign o_write_addr     = r_write_addr;
    assign o_write_char     = r_write_char;
    assign o_write_attr     = r_write_attr;
    assign o_display_update = r_display_update;
    assign o_cursor_out     = r_cursor_out;
    assign o_start_out      = r_start_out;

    assign act_origin = EW'(EW'(r_active) * EW'(REGION));

    a_nop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_cmd.op == OP_NOP) |=> !r_write_valid && !r_display_update)
        else $error("ignored console produced a write or display update");

    a_select_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_cmd.op == OP_SELECT) |=> r_display_update && r_out_valid)
        else $error("console select did not load the display");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col[r_active]} < (COL_W+1)'(SCREEN_COLS))
        else $error("column tracker out of range");

    a_cursor_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (EW'(r_cursor[r_active]) >= act_origin)
        && (EW'(r_cursor[r_active]) < (act_origin + EW'(REGION))))
        else $error("cursor left its console region");

endmodule

`default_nettype wire

FILE: design/text_console_cursor_scroll.sv
// Multi-console text writer. Video memory is split into NUM_CONSOLES equal
// regions; each console has its own cursor and display start, and one console
// is current. Each input transfer puts a character (newline, backspace or a
// printable byte), scrolls a view up or down one line, or selects a console,
// and yields exactly one output transfer with the cell write (if any) and,
// when the addressed console is current, the cursor and start to load.
// Throughput is one item per clock unless the output stalls: the back end
// reads, updates and writes back the addressed console's state as it pops
// each item, so consecutive items to the same console need no stall. Items
// pass through the command queue, then the output register. No clearing pass
// runs after reset; the block is ready at once. The attribute register is
// written through the cfg channel, which is always ready, and is expected to
// change only while the block is idle.
`default_nettype none

module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int NUM_CONSOLES = 4,
    parameter int SCREEN_COLS  = 80,
    parameter int SCREEN_CELLS = 2000,
    parameter int VIDEO_WORDS  = 16384
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // attribute register write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [ATTR_W-1:0]     i_cfg_char_attribute,

    // command input channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_mode,
    input  wire logic [IDX_W-1:0]      i_console_index,
    input  wire logic [CHAR_W-1:0]     i_char_code,

    // result output channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_write_valid,
    output logic [OUT_ADDR_W-1:0]      o_write_addr,
    output logic [CHAR_W-1:0]          o_write_char,
    output logic [ATTR_W-1:0]          o_write_attr,
    output logic                       o_display_update,
    output logic [OUT_ADDR_W-1:0]      o_cursor_out,
    output logic [OUT_ADDR_W-1:0]      o_start_out
);

    logic [ATTR_W-1:0] r_char_attribute;

    logic q_full;
    logic q_nonempty;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    // attribute register: every transfer on the cfg channel loads it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_attribute <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_char_attribute <= i_cfg_char_attribute;
        end
    end

    // front: decode mode/char into an op, drop out-of-range consoles to a no-op
    tccs_front #(
        .NUM_CONSOLES (NUM_CONSOLES)
    ) u_front (
        .i_valid         (i_valid),
        .i_mode          (i_mode),
        .i_console_index (i_console_index),
        .i_char_code     (i_char_code),
        .i_q_full        (q_full),
        .o_ready         (o_ready),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // short queue so input acceptance and output stalls stay decoupled
    tccs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (front_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_cmd      (queue_cmd)
    );

    // back: per-console cursor/view state and the registered result
    tccs_back #(
        .NUM_CONSOLES (NUM_CONSOLES),
        .SCREEN_COLS  (SCREEN_COLS),
        .SCREEN_CELLS (SCREEN_CELLS),
        .VIDEO_WORDS  (VIDEO_WORDS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_nonempty     (q_nonempty),
        .i_cmd            (queue_cmd),
        .i_attr           (r_char_attribute),
        .i_ready          (i_ready),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_write_valid    (o_write_valid),
        .o_write_addr     (o_write_addr),
        .o_write_char     (o_write_char),
        .o_write_attr     (o_write_attr),
        .o_display_update (o_display_update),
        .o_cursor_out     (o_cursor_out),
        .o_start_out      (o_start_out)
    );

endmodule

`default_nettype wire
